// ----- rtl/rts_pkg.sv -----
// rts_pkg: types, codes and constants of the rtc i2c transaction sequencer
// no dependencies; imported by the channel interfaces and every rtl module

package rts_pkg;

  localparam int unsigned NUM_BYTES      = 7;
  localparam int unsigned IDX_W          = $clog2(NUM_BYTES);
  localparam int unsigned ALARM_BYTES    = 4;

  localparam logic [IDX_W-1:0] LAST_IDX       = IDX_W'(NUM_BYTES - 1);
  localparam logic [IDX_W-1:0] ALARM_LAST_IDX = IDX_W'(ALARM_BYTES - 1);
  localparam logic [IDX_W-1:0] ALARM_VAL_CNT  = IDX_W'(ALARM_BYTES - 1);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ADDR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_ADDR  = 1'b1;

  localparam logic [7:0] WRITE_ADDR_RST = 8'hD0;
  localparam logic [7:0] READ_ADDR_RST  = 8'hD1;

  // device register pointers and fixed data bytes
  localparam logic [7:0] PTR_TIME      = 8'h00;
  localparam logic [7:0] PTR_ALARM1    = 8'h07;
  localparam logic [7:0] PTR_CONTROL   = 8'h0E;
  localparam logic [7:0] PTR_STATUS    = 8'h0F;
  localparam logic [7:0] ALARM_MASK    = 8'h7F;
  localparam logic [7:0] ALARM_DAY_ANY = 8'h80;
  localparam logic [7:0] CTRL_VALUE    = 8'b0000_0101;
  localparam logic [7:0] STATUS_CLEAR  = 8'h00;

  // item function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef enum logic [2:0] {
    OP_READ_DT    = 3'd0,
    OP_WRITE_DT   = 3'd1,
    OP_WRITE_AL   = 3'd2,
    OP_CLEAR_AL   = 3'd3,
    OP_WRITE_CTRL = 3'd4,
    OP_NONE       = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_SEND  = 3'd1,
    CMD_START = 3'd2,
    CMD_RACK  = 3'd3,
    CMD_RNACK = 3'd4,
    CMD_STOP  = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_WADDR,
    PH_SETREG,
    PH_RSTART,
    PH_RADDR,
    PH_RD,
    PH_WR,
    PH_AL,
    PH_ALEND,
    PH_CLR,
    PH_CTRL,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic       func;
    logic [2:0] op;
    logic [7:0] wr_seconds;
    logic [7:0] wr_minutes;
    logic [7:0] wr_hours;
    logic [7:0] wr_weekday;
    logic [7:0] wr_monthday;
    logic [7:0] wr_month;
    logic [7:0] wr_year;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] bus_cmd;
    logic [7:0] tx_byte;
    logic       done_res;
    logic [7:0] rd_seconds;
    logic [7:0] rd_minutes;
    logic [7:0] rd_hours;
    logic [7:0] rd_weekday;
    logic [7:0] rd_monthday;
    logic [7:0] rd_month;
    logic [7:0] rd_year;
  } out_item_t;

endpackage

// ----- rtl/rts_if.sv -----
// rts_if: valid/ready channel interfaces for input and result items
// depends on rts_pkg for the payload structs

interface rts_in_if
  import rts_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rts_out_if
  import rts_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/rts_seq.sv -----
// rts_seq: phase state, address registers, write/read byte stores and step logic
// depends on rts_pkg; result is combinational and registered by rts_out_reg

module rts_seq
  import rts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  in_item_t             item_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i,
  output out_item_t            res_o
);

  phase_e                          phase_q, phase_d;
  op_e                             op_q, op_d;
  logic [IDX_W-1:0]                idx_q, idx_d;
  logic [7:0]                      waddr_q, raddr_q;
  logic [NUM_BYTES-1:0][7:0]       wv_q, wv_d;
  logic [NUM_BYTES-1:0][7:0]       rv_q, rv_d;
  cmd_e                            cmd;
  logic [7:0]                      tx;
  logic                            done;

  always_comb begin
    phase_d = phase_q;
    op_d    = op_q;
    idx_d   = idx_q;
    wv_d    = wv_q;
    rv_d    = rv_q;
    cmd     = CMD_NONE;
    tx      = '0;
    done    = 1'b0;
    if (step_i) begin
      if (item_i.func == FUNC_START) begin
        // start is dropped while busy or for an unknown operation
        if (phase_q == PH_IDLE && item_i.op <= 3'(OP_WRITE_CTRL)) begin
          op_d    = op_e'(item_i.op);
          wv_d    = {item_i.wr_year, item_i.wr_month, item_i.wr_monthday,
                     item_i.wr_weekday, item_i.wr_hours, item_i.wr_minutes,
                     item_i.wr_seconds};
          phase_d = PH_START;
          cmd     = CMD_START;
        end
      end else begin
        case (phase_q)
          PH_IDLE: begin
          end
          PH_START: begin
            cmd     = CMD_SEND;
            tx      = waddr_q;
            phase_d = PH_WADDR;
          end
          PH_WADDR: begin
            cmd   = CMD_SEND;
            idx_d = '0;
            case (op_q)
              OP_READ_DT: begin
                tx      = PTR_TIME;
                phase_d = PH_SETREG;
              end
              OP_WRITE_DT: begin
                tx      = PTR_TIME;
                phase_d = PH_WR;
              end
              OP_WRITE_AL: begin
                tx      = PTR_ALARM1;
                phase_d = PH_AL;
              end
              OP_CLEAR_AL: begin
                tx      = PTR_STATUS;
                phase_d = PH_CLR;
              end
              OP_WRITE_CTRL: begin
                tx      = PTR_CONTROL;
                phase_d = PH_CTRL;
              end
              default: begin
                cmd     = CMD_NONE;
                phase_d = PH_IDLE;
                op_d    = OP_NONE;
              end
            endcase
          end
          PH_SETREG: begin
            cmd     = CMD_START;
            phase_d = PH_RSTART;
          end
          PH_RSTART: begin
            cmd     = CMD_SEND;
            tx      = raddr_q;
            phase_d = PH_RADDR;
          end
          PH_RADDR: begin
            cmd     = CMD_RACK;
            idx_d   = '0;
            phase_d = PH_RD;
          end
          PH_RD: begin
            rv_d[idx_q] = item_i.rx_byte;
            if (idx_q != LAST_IDX) begin
              cmd   = CMD_RACK;
              idx_d = idx_q + IDX_W'(1);
            end else begin
              cmd     = CMD_RNACK;
              phase_d = PH_DONE;
            end
          end
          PH_WR: begin
            cmd = CMD_SEND;
            tx  = wv_q[idx_q];
            if (idx_q != LAST_IDX) begin
              idx_d = idx_q + IDX_W'(1);
            end else begin
              phase_d = PH_DONE;
            end
          end
          PH_AL: begin
            cmd   = CMD_SEND;
            // three masked time bytes, then the day byte that matches any day
            tx    = (idx_q < ALARM_VAL_CNT) ? (wv_q[idx_q] & ALARM_MASK) : ALARM_DAY_ANY;
            idx_d = idx_q + IDX_W'(1);
            if (idx_q == ALARM_LAST_IDX) begin
              phase_d = PH_ALEND;
            end
          end
          PH_ALEND: begin
            // chain straight into the control register write
            op_d    = OP_WRITE_CTRL;
            phase_d = PH_START;
            cmd     = CMD_START;
          end
          PH_CLR: begin
            cmd     = CMD_SEND;
            tx      = STATUS_CLEAR;
            phase_d = PH_DONE;
          end
          PH_CTRL: begin
            cmd     = CMD_SEND;
            tx      = CTRL_VALUE;
            phase_d = PH_DONE;
          end
          PH_DONE: begin
            cmd     = CMD_STOP;
            done    = 1'b1;
            phase_d = PH_IDLE;
            op_d    = OP_NONE;
          end
          default: begin
            phase_d = PH_IDLE;
            op_d    = OP_NONE;
          end
        endcase
      end
    end
  end

  always_comb begin
    res_o.bus_cmd     = cmd;
    res_o.tx_byte     = tx;
    res_o.done_res    = done;
    res_o.rd_seconds  = rv_d[0];
    res_o.rd_minutes  = rv_d[1];
    res_o.rd_hours    = rv_d[2];
    res_o.rd_weekday  = rv_d[3];
    res_o.rd_monthday = rv_d[4];
    res_o.rd_month    = rv_d[5];
    res_o.rd_year     = rv_d[6];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      op_q    <= OP_NONE;
      idx_q   <= '0;
      rv_q    <= '0;
      waddr_q <= WRITE_ADDR_RST;
      raddr_q <= READ_ADDR_RST;
    end else begin
      phase_q <= phase_d;
      op_q    <= op_d;
      idx_q   <= idx_d;
      rv_q    <= rv_d;
      if (cfg_we_i && cfg_idx_i == REG_WRITE_ADDR) begin
        waddr_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == REG_READ_ADDR) begin
        raddr_q <= cfg_wdata_i;
      end
    end
  end

  // write bytes are loaded by every start before use
  always_ff @(posedge clk_i) begin
    wv_q <= wv_d;
  end

endmodule

// ----- rtl/rts_out_reg.sv -----
// rts_out_reg: result register between the step logic and the result channel
// depends on rts_pkg for the result struct

module rts_out_reg
  import rts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  out_item_t res_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  output logic      in_ready_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  // a held result leaves in the same cycle a new one is loaded
  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

// ----- rtl/rtc_i2c_transaction_sequencer.sv -----
// rtc_i2c_transaction_sequencer: top level of the i2c rtc byte sequencer
// depends on rts_pkg, rts_if, rts_seq and rts_out_reg
//
//   channel   dir  handshake     payload
//   in_ch     in   valid/ready   in_item_t  (func, op, seven write bytes, rx_byte)
//   out_ch    out  valid/ready   out_item_t (bus_cmd, tx_byte, done_res, seven read bytes)
//   cfg       in   cfg_we_i      cfg_idx_i selects write or read address, cfg_wdata_i
//
// every item gives exactly one result, in the cycle after acceptance, from the output register
// one item per cycle unless out_ch stalls a held result: the step logic is a single phase transition plus a byte select
// in_ch.ready is low only while a result waits in the output register and out_ch is stalled
// reset clears phase, operation, read bytes and the output valid; addresses go to 0xD0/0xD1

module rtc_i2c_transaction_sequencer
  import rts_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rts_in_if.sink               in_ch,
  rts_out_if.source            out_ch,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]           cfg_wdata_i
);

  logic      in_ready;
  logic      accept;
  out_item_t res;

  assign in_ch.ready = in_ready;
  assign accept      = in_ch.valid && in_ready;

  // state update and result computation for the accepted item
  rts_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .item_i      (in_ch.payload),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res)
  );

  // result register, decouples the two channels
  rts_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_item_o  (out_ch.payload),
    .in_ready_o  (in_ready)
  );

endmodule

// ----- tb/sv/rtc_i2c_transaction_sequencer_tb.sv -----
// rtc_i2c_transaction_sequencer_tb: self-checking bench for the i2c rtc byte sequencer
// drives item streams against a cycle-free predictor of the sequencer and checks every result
// depends on rts_pkg, rts_if and the rtc_i2c_transaction_sequencer rtl

module rtc_i2c_transaction_sequencer_tb;
  import rts_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [7:0] cfg_wdata;

  rts_in_if in_ch ();
  rts_out_if out_ch ();

  rtc_i2c_transaction_sequencer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // sequencer predictor state
  // ---------------------------------------------------------------------------
  phase_e     seq_phase;
  op_e        seq_op;
  int         byte_idx;
  logic [7:0] wr_bytes [NUM_BYTES];
  logic [7:0] rd_bytes [NUM_BYTES];
  logic [7:0] write_addr_reg;
  logic [7:0] read_addr_reg;

  out_item_t  bus_result_q [$];  // predicted results, oldest first
  int         errors;
  int         active_items;      // items the block acted on (not ignored)
  int         cycle_count;
  bit         gaps_on;           // random idling on both sides
  int         hold_off_cycles;   // one-shot long receiver stall request

  // advances the predictor by one accepted item and returns the bus result
  function automatic out_item_t sequence_step(in_item_t it);
    out_item_t r;
    r = '0;
    r.bus_cmd = CMD_NONE;
    if (it.func == FUNC_START) begin
      // start is only taken while idle and with a known operation
      if (seq_phase == PH_IDLE && it.op <= OP_WRITE_CTRL) begin
        seq_op = op_e'(it.op);
        wr_bytes[0] = it.wr_seconds;
        wr_bytes[1] = it.wr_minutes;
        wr_bytes[2] = it.wr_hours;
        wr_bytes[3] = it.wr_weekday;
        wr_bytes[4] = it.wr_monthday;
        wr_bytes[5] = it.wr_month;
        wr_bytes[6] = it.wr_year;
        seq_phase = PH_START;
        r.bus_cmd = CMD_START;
      end
    end else begin
      case (seq_phase)
        PH_START: begin
          r.bus_cmd = CMD_SEND;
          r.tx_byte = write_addr_reg;
          seq_phase = PH_WADDR;
        end
        PH_WADDR: begin
          // register pointer depends on the operation
          r.bus_cmd = CMD_SEND;
          byte_idx = 0;
          case (seq_op)
            OP_READ_DT: begin
              r.tx_byte = PTR_TIME;
              seq_phase = PH_SETREG;
            end
            OP_WRITE_DT: begin
              r.tx_byte = PTR_TIME;
              seq_phase = PH_WR;
            end
            OP_WRITE_AL: begin
              r.tx_byte = PTR_ALARM1;
              seq_phase = PH_AL;
            end
            OP_CLEAR_AL: begin
              r.tx_byte = PTR_STATUS;
              seq_phase = PH_CLR;
            end
            OP_WRITE_CTRL: begin
              r.tx_byte = PTR_CONTROL;
              seq_phase = PH_CTRL;
            end
            default: begin
              r.bus_cmd = CMD_NONE;
              seq_phase = PH_IDLE;
              seq_op = OP_NONE;
            end
          endcase
        end
        PH_SETREG: begin
          r.bus_cmd = CMD_START;
          seq_phase = PH_RSTART;
        end
        PH_RSTART: begin
          r.bus_cmd = CMD_SEND;
          r.tx_byte = read_addr_reg;
          seq_phase = PH_RADDR;
        end
        PH_RADDR: begin
          r.bus_cmd = CMD_RACK;
          byte_idx = 0;
          seq_phase = PH_RD;
        end
        PH_RD: begin
          // capture, then ack all but the last byte
          rd_bytes[byte_idx] = it.rx_byte;
          if (byte_idx < NUM_BYTES - 1) begin
            r.bus_cmd = CMD_RACK;
            byte_idx++;
          end else begin
            r.bus_cmd = CMD_RNACK;
            seq_phase = PH_DONE;
          end
        end
        PH_WR: begin
          r.bus_cmd = CMD_SEND;
          r.tx_byte = wr_bytes[byte_idx];
          if (byte_idx < NUM_BYTES - 1) byte_idx++;
          else seq_phase = PH_DONE;
        end
        PH_AL: begin
          // three masked time bytes, then the day byte with the any flag
          r.bus_cmd = CMD_SEND;
          r.tx_byte = (byte_idx < ALARM_BYTES - 1) ? (wr_bytes[byte_idx] & ALARM_MASK)
                                                   : ALARM_DAY_ANY;
          if (byte_idx < ALARM_BYTES - 1) byte_idx++;
          else seq_phase = PH_ALEND;
        end
        PH_ALEND: begin
          // alarm write chains into a control register write
          seq_op = OP_WRITE_CTRL;
          seq_phase = PH_START;
          r.bus_cmd = CMD_START;
        end
        PH_CLR: begin
          r.bus_cmd = CMD_SEND;
          r.tx_byte = STATUS_CLEAR;
          seq_phase = PH_DONE;
        end
        PH_CTRL: begin
          r.bus_cmd = CMD_SEND;
          r.tx_byte = CTRL_VALUE;
          seq_phase = PH_DONE;
        end
        PH_DONE: begin
          r.bus_cmd = CMD_STOP;
          r.done_res = 1'b1;
          seq_phase = PH_IDLE;
          seq_op = OP_NONE;
        end
        default: ;  // step while idle is ignored
      endcase
    end
    r.rd_seconds  = rd_bytes[0];
    r.rd_minutes  = rd_bytes[1];
    r.rd_hours    = rd_bytes[2];
    r.rd_weekday  = rd_bytes[3];
    r.rd_monthday = rd_bytes[4];
    r.rd_month    = rd_bytes[5];
    r.rd_year     = rd_bytes[6];
    return r;
  endfunction

  function automatic in_item_t random_fields();
    in_item_t it;
    it.func        = 1'($urandom_range(0, 1));
    it.op          = 3'($urandom_range(0, 7));
    it.wr_seconds  = 8'($urandom_range(0, 255));
    it.wr_minutes  = 8'($urandom_range(0, 255));
    it.wr_hours    = 8'($urandom_range(0, 255));
    it.wr_weekday  = 8'($urandom_range(0, 255));
    it.wr_monthday = 8'($urandom_range(0, 255));
    it.wr_month    = 8'($urandom_range(0, 255));
    it.wr_year     = 8'($urandom_range(0, 255));
    it.rx_byte     = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // driving helpers
  // ---------------------------------------------------------------------------

  // offers one item after a random gap and predicts its result on acceptance
  task automatic send_item(in_item_t it);
    int gap;
    out_item_t r;
    gap = gaps_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.payload = it;
    do @(posedge clk); while (!in_ch.ready);
    r = sequence_step(it);
    bus_result_q.push_back(r);
    if (r.bus_cmd != CMD_NONE) active_items++;
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic wait_drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (bus_result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = data;
    case (idx)
      REG_WRITE_ADDR: write_addr_reg = data;
      REG_READ_ADDR:  read_addr_reg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic start_op(logic [2:0] op, logic [7:0] fill);
    in_item_t it;
    it = random_fields();
    it.func = FUNC_START;
    it.op = op;
    it.wr_seconds  = fill;
    it.wr_minutes  = fill;
    it.wr_hours    = fill;
    it.wr_weekday  = fill;
    it.wr_monthday = fill;
    it.wr_month    = fill;
    it.wr_year     = fill;
    send_item(it);
  endtask

  // bus steps until the sequencer is back to idle; noisy adds starts while busy and pauses
  task automatic finish_transaction(bit noisy);
    in_item_t it;
    while (seq_phase != PH_IDLE) begin
      it = random_fields();
      it.func = FUNC_STEP;
      if (noisy && $urandom_range(0, 15) == 0) it.func = FUNC_START;
      if (noisy && $urandom_range(0, 63) == 0) wait_drain();
      send_item(it);
    end
  endtask

  task automatic random_transaction();
    in_item_t it;
    it = random_fields();
    if ($urandom_range(0, 9) == 0) begin
      // broken stream: fully random items, may leave an operation half done
      repeat ($urandom_range(1, 10)) send_item(random_fields());
    end else begin
      it.func = FUNC_START;
      it.op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      send_item(it);
      finish_transaction(1'b1);
      if ($urandom_range(0, 7) == 0) begin
        it = random_fields();
        it.func = FUNC_STEP;
        send_item(it);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // step while idle, and starts with unknown operations
  task automatic test_ignored_items();
    in_item_t it;
    it = '1;  // func high: bus step with every field at its top value
    send_item(it);
    start_op(3'd5, 8'hFF);  // first code past the known operations
    start_op(OP_NONE, 8'h00);
  endtask

  // alarm write with all-ones values checks the mask, then chains into control
  task automatic test_alarm_chain();
    start_op(OP_WRITE_AL, 8'hFF);
    send_item('{func: FUNC_STEP, op: OP_READ_DT, wr_seconds: 8'h00, wr_minutes: 8'h00,
                wr_hours: 8'h00, wr_weekday: 8'h00, wr_monthday: 8'h00,
                wr_month: 8'h00, wr_year: 8'h00, rx_byte: 8'h00});
    // start while busy must be dropped
    start_op(OP_READ_DT, 8'h5A);
    finish_transaction(1'b0);
  endtask

  task automatic test_clear_and_control();
    start_op(OP_CLEAR_AL, 8'h00);
    finish_transaction(1'b0);
    start_op(OP_WRITE_CTRL, 8'hA5);
    finish_transaction(1'b0);
  endtask

  // long receiver stall while the sender keeps offering back to back
  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    hold_off_cycles = 300;
    start_op(OP_READ_DT, 8'h00);
    finish_transaction(1'b0);
    start_op(OP_WRITE_DT, 8'hFF);
    finish_transaction(1'b0);
    wait_drain();
    gaps_on = 1'b1;
  endtask

  // sender pauses mid operation until every result is back
  task automatic test_sender_pause();
    in_item_t it;
    start_op(OP_WRITE_DT, 8'h3C);
    repeat (3) begin
      it = random_fields();
      it.func = FUNC_STEP;
      send_item(it);
    end
    wait_drain();
    finish_transaction(1'b0);
  endtask

  task automatic test_random_traffic(int target, logic [7:0] waddr, logic [7:0] raddr);
    int first;
    wait_drain();
    write_reg(REG_WRITE_ADDR, waddr);
    write_reg(REG_READ_ADDR, raddr);
    first = active_items;
    while (active_items - first < target) begin
      if ($urandom_range(0, 5) == 0) gaps_on = ($urandom_range(0, 2) != 0);
      random_transaction();
    end
    finish_transaction(1'b0);
    gaps_on = 1'b1;
    wait_drain();
  endtask

  // ---------------------------------------------------------------------------
  // result checker: random stalls, compares each result with the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
      errors++;
    end
  endtask

  initial begin : result_sink
    int stall;
    out_item_t got;
    out_item_t want;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = gaps_on ? $urandom_range(0, 15) : 0;
      if (hold_off_cycles > 0) begin
        stall = hold_off_cycles;
        hold_off_cycles = 0;
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = out_ch.payload;
      if (bus_result_q.size() == 0) begin
        $error("result with no item pending: bus_cmd %0d tx_byte 0x%02h",
               got.bus_cmd, got.tx_byte);
        errors++;
      end else begin
        want = bus_result_q.pop_front();
        check_field("bus_cmd", 8'(want.bus_cmd), 8'(got.bus_cmd));
        check_field("tx_byte", want.tx_byte, got.tx_byte);
        check_field("done_res", 8'(want.done_res), 8'(got.done_res));
        check_field("rd_seconds", want.rd_seconds, got.rd_seconds);
        check_field("rd_minutes", want.rd_minutes, got.rd_minutes);
        check_field("rd_hours", want.rd_hours, got.rd_hours);
        check_field("rd_weekday", want.rd_weekday, got.rd_weekday);
        check_field("rd_monthday", want.rd_monthday, got.rd_monthday);
        check_field("rd_month", want.rd_month, got.rd_month);
        check_field("rd_year", want.rd_year, got.rd_year);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rtc_i2c_transaction_sequencer regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // predictor starts in the reset state
    seq_phase = PH_IDLE;
    seq_op = OP_NONE;
    byte_idx = 0;
    write_addr_reg = WRITE_ADDR_RST;
    read_addr_reg = READ_ADDR_RST;
    for (int k = 0; k < NUM_BYTES; k++) begin
      wr_bytes[k] = '0;
      rd_bytes[k] = '0;
    end
    errors = 0;
    active_items = 0;
    cycle_count = 0;
    gaps_on = 1'b1;
    hold_off_cycles = 0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_ignored_items();
    test_alarm_chain();
    test_clear_and_control();
    test_output_backpressure();
    test_sender_pause();
    test_random_traffic(250, 8'h00, 8'hFF);
    test_random_traffic(250, 8'hFF, 8'h00);
    test_random_traffic(250, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    test_random_traffic(250, WRITE_ADDR_RST, READ_ADDR_RST);

    wait_drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && bus_result_q.size() == 0) begin
      $display("rtc_i2c_transaction_sequencer regression: pass");
    end else begin
      $display("rtc_i2c_transaction_sequencer regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rts_pkg.sv
rtl/rts_if.sv
rtl/rts_seq.sv
rtl/rts_out_reg.sv
rtl/rtc_i2c_transaction_sequencer.sv
tb/sv/rtc_i2c_transaction_sequencer_tb.sv
